[rtl/sft_pkg.sv]
// shared types, constants and codes for the syn flood source tracker
`timescale 1ns / 1ps
package sft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int EVICT_LIMIT = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;

    localparam logic [2:0] OP_EVENT    = 3'd0;
    localparam logic [2:0] OP_FLOW     = 3'd1;
    localparam logic [2:0] OP_SNAPSHOT = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_EXPIRE   = 3'd4;

    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_BLOCKED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic [2:0] CFG_FLAG_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_WINDOW       = 3'd1;
    localparam logic [2:0] CFG_BLOCK_ENABLE = 3'd2;
    localparam logic [2:0] CFG_BLOCK_TTL    = 3'd3;
    localparam logic [2:0] CFG_IDLE_TTL     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] syns;
        logic [31:0] acks;
        logic [63:0] last_event;
        logic [31:0] gen;
        logic        flagged;
        logic        blocked;
        logic [63:0] block_start;
        logic [7:0]  ttl_seen;
        logic        sum_present;
        logic [31:0] sum_syns;
        logic [31:0] sum_acks;
        logic [63:0] sum_last;
    } t_slot;

    typedef struct packed {
        logic [31:0] flag_level;
        logic [63:0] window_ns;
        logic        block_enable;
        logic [63:0] block_ttl_ns;
        logic [63:0] idle_ttl_ns;
    } t_cfg;

    typedef struct packed {
        logic       take;
        logic       evict;
        logic       cand;
        logic [1:0] cand_kind;
        logic       find;
    } t_head_ctl;

endpackage

[rtl/sft_cell.sv]
// one table slot of the rotating chain with its address compare
`timescale 1ns / 1ps
module sft_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  sft_pkg::t_slot       i_rec,
    input  logic [31:0]          i_addr,
    output sft_pkg::t_slot       o_rec,
    output logic                 o_hit
);
    import sft_pkg::*;

    t_slot r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid       <= 1'b0;
            r_rec.flagged     <= 1'b0;
            r_rec.blocked     <= 1'b0;
            r_rec.sum_present <= 1'b0;
        end else if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = r_rec.valid && (r_rec.addr == i_addr);

endmodule

[rtl/sft_head.sv]
// update of the slot record passing the head of the chain
`timescale 1ns / 1ps
module sft_head (
    input  sft_pkg::t_slot       i_rec,
    input  sft_pkg::t_cfg        i_cfg,
    input  logic [2:0]           i_operation,
    input  logic [31:0]          i_src_ip,
    input  logic [7:0]           i_ttl,
    input  logic [63:0]          i_event_time,
    input  logic [7:0]           i_protocol,
    input  logic [31:0]          i_flow_syns,
    input  logic [31:0]          i_flow_acks,
    input  logic [63:0]          i_first_seen,
    input  logic [63:0]          i_last_seen,
    input  logic [63:0]          i_time_now,
    input  logic [31:0]          i_gen,
    input  logic                 i_over,
    input  logic                 i_hit,
    input  logic                 i_taken,
    output sft_pkg::t_slot       o_rec,
    output sft_pkg::t_head_ctl   o_ctl
);
    import sft_pkg::*;

    function automatic logic aged(input logic [63:0] now, input logic [63:0] then_t,
                                  input logic [63:0] lim);
        logic [63:0] diff;
        diff = now - then_t;
        return (now > then_t) && (diff > lim);
    endfunction

    t_slot       s_rec;
    logic        keep;
    logic        find;
    logic        take;
    logic        sel;
    logic [31:0] unmatched;
    logic [63:0] held;

    always_comb begin
        s_rec     = i_rec;
        o_ctl     = '0;
        unmatched = '0;
        held      = i_time_now - i_rec.block_start;
        keep = (i_operation == OP_FLOW) && (i_protocol == TCP_PROTOCOL) &&
               (i_last_seen != 64'd0) && !aged(i_time_now, i_last_seen, i_cfg.window_ns) &&
               !((i_first_seen != 64'd0) && aged(i_time_now, i_first_seen, i_cfg.window_ns));
        find = (i_operation == OP_EVENT) || keep;
        take = find && !i_hit && !i_taken && !i_rec.valid;
        sel  = find && ((i_rec.valid && (i_rec.addr == i_src_ip)) || take);
        if (take) begin
            s_rec       = '0;
            s_rec.valid = 1'b1;
            s_rec.addr  = i_src_ip;
        end
        case (i_operation)
            OP_EVENT: begin
                if (sel) begin
                    if (i_ttl != 8'd0) s_rec.ttl_seen = i_ttl;
                    if (i_event_time > s_rec.last_event) s_rec.last_event = i_event_time;
                end
            end
            OP_FLOW: begin
                if (sel) begin
                    if (s_rec.sum_present) begin
                        s_rec.sum_syns = s_rec.sum_syns + i_flow_syns;
                        s_rec.sum_acks = s_rec.sum_acks + i_flow_acks;
                        if (i_last_seen > s_rec.sum_last) s_rec.sum_last = i_last_seen;
                    end else begin
                        s_rec.sum_present = 1'b1;
                        s_rec.sum_syns    = i_flow_syns;
                        s_rec.sum_acks    = i_flow_acks;
                        s_rec.sum_last    = i_last_seen;
                    end
                end
            end
            OP_SNAPSHOT: begin
                if (s_rec.valid && s_rec.sum_present) begin
                    s_rec.sum_present = 1'b0;
                    s_rec.syns        = s_rec.sum_syns;
                    s_rec.acks        = s_rec.sum_acks;
                    s_rec.last_event  = s_rec.sum_last;
                    s_rec.gen         = i_gen;
                    if (s_rec.syns > s_rec.acks) unmatched = s_rec.syns - s_rec.acks;
                    if (unmatched >= i_cfg.flag_level) s_rec.flagged = 1'b1;
                end
                if (s_rec.valid && (s_rec.gen != i_gen) && !s_rec.blocked) begin
                    if ((s_rec.last_event == 64'd0) ||
                        aged(i_time_now, s_rec.last_event, i_cfg.window_ns)) begin
                        s_rec.syns    = '0;
                        s_rec.acks    = '0;
                        s_rec.flagged = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (s_rec.valid && s_rec.flagged && !s_rec.blocked && i_cfg.block_enable) begin
                    s_rec.blocked     = 1'b1;
                    s_rec.block_start = i_time_now;
                    o_ctl.cand        = 1'b1;
                    o_ctl.cand_kind   = KIND_BLOCKED;
                end
                if (i_over && s_rec.valid && !s_rec.flagged && !s_rec.blocked &&
                    !s_rec.sum_present &&
                    aged(i_time_now, s_rec.last_event, i_cfg.idle_ttl_ns)) begin
                    s_rec.valid = 1'b0;
                    o_ctl.evict = 1'b1;
                end
            end
            OP_EXPIRE: begin
                if (s_rec.valid && s_rec.blocked && (i_time_now >= s_rec.block_start) &&
                    (held >= i_cfg.block_ttl_ns)) begin
                    s_rec.blocked   = 1'b0;
                    s_rec.flagged   = 1'b0;
                    s_rec.syns      = '0;
                    s_rec.acks      = '0;
                    o_ctl.cand      = 1'b1;
                    o_ctl.cand_kind = KIND_EXPIRED;
                end
            end
            default: begin
            end
        endcase
        o_ctl.take = take;
        o_ctl.find = find;
        o_rec      = s_rec;
    end

endmodule

[rtl/syn_flood_source_tracker.sv]
// top level: slot chain, head update, control and result register
//
//  channel   signals                                  direction
//  input     i_valid / o_ready, i_operation..i_time_now  in
//  result    o_valid / i_ready, o_result_kind, o_address, o_last  out
//  config    i_cfg_we, i_cfg_index, i_cfg_data        in
//
// every item rotates the whole slot chain once past the head, and the
// final result is posted after the rotation.
// reset clears the control bits of all slots at once; no clearing pass.
// the rotation freezes only when a listed source meets a full hold register
// while the result register is stalled; the final result waits the same way.
`timescale 1ns / 1ps
module syn_flood_source_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_src_ip,
    input  logic [7:0]  i_ttl,
    input  logic [63:0] i_event_time,
    input  logic [7:0]  i_protocol,
    input  logic [31:0] i_flow_syns,
    input  logic [31:0] i_flow_acks,
    input  logic [63:0] i_first_seen,
    input  logic [63:0] i_last_seen,
    input  logic [63:0] i_time_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_address,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sft_pkg::*;

    t_state      r_state, n_state;
    t_cfg        r_cfg;
    logic [2:0]  r_op;
    logic [31:0] r_src;
    logic [7:0]  r_ttl;
    logic [63:0] r_ev_time;
    logic [7:0]  r_proto;
    logic [31:0] r_fsyn;
    logic [31:0] r_fack;
    logic [63:0] r_first;
    logic [63:0] r_lastseen;
    logic [63:0] r_now;
    logic [31:0] r_gen;
    logic [31:0] n_gen;
    logic        r_hit;
    logic        r_over;
    logic        r_taken;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_used;
    logic        r_hold_v;
    logic [1:0]  r_hold_kind;
    logic [31:0] r_hold_addr;
    logic        r_out_v;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_addr;
    logic        r_out_last;

    t_slot       w_rec [TABLE_DEPTH];
    t_slot       w_head_rec;
    logic [TABLE_DEPTH-1:0] w_hit;
    t_head_ctl   w_ctl;

    logic        accept;
    logic        out_busy;
    logic        step;
    logic        fin_load;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == TABLE_DEPTH - 1) begin : g_tail
            sft_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (step),
                .i_rec   (w_head_rec),
                .i_addr  (i_src_ip),
                .o_rec   (w_rec[k]),
                .o_hit   (w_hit[k])
            );
        end else begin : g_mid
            sft_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (step),
                .i_rec   (w_rec[k+1]),
                .i_addr  (i_src_ip),
                .o_rec   (w_rec[k]),
                .o_hit   (w_hit[k])
            );
        end
    end

    sft_head u_head (
        .i_rec        (w_rec[0]),
        .i_cfg        (r_cfg),
        .i_operation  (r_op),
        .i_src_ip     (r_src),
        .i_ttl        (r_ttl),
        .i_event_time (r_ev_time),
        .i_protocol   (r_proto),
        .i_flow_syns  (r_fsyn),
        .i_flow_acks  (r_fack),
        .i_first_seen (r_first),
        .i_last_seen  (r_lastseen),
        .i_time_now   (r_now),
        .i_gen        (r_gen),
        .i_over       (r_over),
        .i_hit        (r_hit),
        .i_taken      (r_taken),
        .o_rec        (w_head_rec),
        .o_ctl        (w_ctl)
    );

    assign out_busy = r_out_v && !i_ready;
    assign n_gen    = (r_gen + 32'd1 == 32'd0) ? 32'd1 : r_gen + 32'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_SCAN;
            ST_SCAN: if (step && (r_idx == IDX_W'(TABLE_DEPTH - 1))) n_state = ST_FIN;
            ST_FIN:  if (!out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready  = 1'b0;
        step     = 1'b0;
        fin_load = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_SCAN: step = !(w_ctl.cand && r_hold_v && out_busy);
            ST_FIN:  fin_load = !out_busy;
            default: begin
            end
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_level   <= 32'd100;
            r_cfg.window_ns    <= 64'd10000000000;
            r_cfg.block_enable <= 1'b1;
            r_cfg.block_ttl_ns <= 64'd300000000000;
            r_cfg.idle_ttl_ns  <= 64'd60000000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLAG_LEVEL:   r_cfg.flag_level   <= i_cfg_data[31:0];
                CFG_WINDOW:       r_cfg.window_ns    <= i_cfg_data;
                CFG_BLOCK_ENABLE: r_cfg.block_enable <= i_cfg_data[0];
                CFG_BLOCK_TTL:    r_cfg.block_ttl_ns <= i_cfg_data;
                CFG_IDLE_TTL:     r_cfg.idle_ttl_ns  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_operation;
            r_src      <= i_src_ip;
            r_ttl      <= i_ttl;
            r_ev_time  <= i_event_time;
            r_proto    <= i_protocol;
            r_fsyn     <= i_flow_syns;
            r_fack     <= i_flow_acks;
            r_first    <= i_first_seen;
            r_lastseen <= i_last_seen;
            r_now      <= i_time_now;
            r_hit      <= |w_hit;
            r_over     <= (r_used > CNT_W'(EVICT_LIMIT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= '0;
            r_used   <= '0;
            r_idx    <= '0;
            r_taken  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (accept) begin
                if (i_operation == OP_SNAPSHOT) r_gen <= n_gen;
                r_idx    <= '0;
                r_taken  <= 1'b0;
                r_hold_v <= 1'b0;
            end else if (step) begin
                r_idx <= r_idx + IDX_W'(1);
                if (w_ctl.take) begin
                    r_taken <= 1'b1;
                    r_used  <= r_used + CNT_W'(1);
                end else if (w_ctl.evict) begin
                    r_used  <= r_used - CNT_W'(1);
                end
                if (w_ctl.cand) begin
                    r_hold_v    <= 1'b1;
                    r_hold_kind <= w_ctl.cand_kind;
                    r_hold_addr <= w_rec[0].addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step && w_ctl.cand && r_hold_v) begin
            r_out_v    <= 1'b1;
            r_out_kind <= r_hold_kind;
            r_out_addr <= r_hold_addr;
            r_out_last <= 1'b0;
        end else if (fin_load) begin
            r_out_v    <= 1'b1;
            r_out_last <= 1'b1;
            if (r_hold_v) begin
                r_out_kind <= r_hold_kind;
                r_out_addr <= r_hold_addr;
            end else if (w_ctl.find && !r_hit && !r_taken) begin
                r_out_kind <= KIND_FULL;
                r_out_addr <= r_src;
            end else begin
                r_out_kind <= KIND_DONE;
                r_out_addr <= '0;
            end
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid       = r_out_v;
    assign o_result_kind = r_out_kind;
    assign o_address     = r_out_addr;
    assign o_last        = r_out_last;

endmodule

[tb/sv/testbench.sv]
// testbench for the syn flood source tracker: predictor scoreboard, random and directed items
`timescale 1ns / 1ps
module testbench;
    import sft_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] src;
        logic [7:0]  ttl;
        logic [63:0] ev_time;
        logic [7:0]  proto;
        logic [31:0] fsyn;
        logic [31:0] fack;
        logic [63:0] first;
        logic [63:0] lastseen;
        logic [63:0] now;
    } t_item;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic        last;
    } t_result;

    class tracker_scoreboard;
        logic [31:0] thr;
        logic [63:0] win;
        logic        auto_blk;
        logic [63:0] blk_ttl;
        logic [63:0] idle_ttl;
        t_slot       slots[TABLE_DEPTH];
        logic [31:0] gen_count;
        t_result     pending[$];
        int          errors;

        function new();
            thr      = 32'd100;
            win      = 64'd10000000000;
            auto_blk = 1'b1;
            blk_ttl  = 64'd300000000000;
            idle_ttl = 64'd60000000000;
            foreach (slots[i]) slots[i] = '0;
            gen_count = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                CFG_FLAG_LEVEL:   thr = data[31:0];
                CFG_WINDOW:       win = data;
                CFG_BLOCK_ENABLE: auto_blk = data[0];
                CFG_BLOCK_TTL:    blk_ttl = data;
                CFG_IDLE_TTL:     idle_ttl = data;
                default: ;
            endcase
        endfunction

        function bit too_old(logic [63:0] now, logic [63:0] then, logic [63:0] lim);
            return now > then && now - then > lim;
        endfunction

        function int locate_slot(logic [31:0] addr);
            int free_idx;
            free_idx = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slots[i].valid) begin
                    if (slots[i].addr == addr) return i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (free_idx >= 0) begin
                slots[free_idx] = '0;
                slots[free_idx].valid = 1'b1;
                slots[free_idx].addr = addr;
            end
            return free_idx;
        endfunction

        function void push(logic [1:0] kind, logic [31:0] addr);
            t_result r;
            r.kind = kind;
            r.addr = addr;
            r.last = 1'b0;
            pending.insert(pending.size(), r);
        endfunction

        function void note_item(t_item it);
            int s;
            int used;
            int n;
            logic [31:0] unmatched;
            n = pending.size();
            case (it.op)
                OP_EVENT: begin
                    s = locate_slot(it.src);
                    if (s < 0) push(KIND_FULL, it.src);
                    else begin
                        if (it.ttl != 0) slots[s].ttl_seen = it.ttl;
                        if (it.ev_time > slots[s].last_event) slots[s].last_event = it.ev_time;
                    end
                end
                OP_FLOW: begin
                    if (it.proto == TCP_PROTOCOL && it.lastseen != 0 &&
                        !too_old(it.now, it.lastseen, win) &&
                        !(it.first != 0 && too_old(it.now, it.first, win))) begin
                        s = locate_slot(it.src);
                        if (s < 0) push(KIND_FULL, it.src);
                        else if (slots[s].sum_present) begin
                            slots[s].sum_syns += it.fsyn;
                            slots[s].sum_acks += it.fack;
                            if (it.lastseen > slots[s].sum_last) slots[s].sum_last = it.lastseen;
                        end else begin
                            slots[s].sum_present = 1'b1;
                            slots[s].sum_syns = it.fsyn;
                            slots[s].sum_acks = it.fack;
                            slots[s].sum_last = it.lastseen;
                        end
                    end
                end
                OP_SNAPSHOT: begin
                    gen_count++;
                    if (gen_count == 0) gen_count++;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slots[i].valid && slots[i].sum_present) begin
                            slots[i].sum_present = 1'b0;
                            slots[i].syns = slots[i].sum_syns;
                            slots[i].acks = slots[i].sum_acks;
                            slots[i].last_event = slots[i].sum_last;
                            slots[i].gen = gen_count;
                            unmatched = slots[i].syns > slots[i].acks ?
                                        slots[i].syns - slots[i].acks : 32'd0;
                            if (unmatched >= thr) slots[i].flagged = 1'b1;
                        end
                    end
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slots[i].valid && slots[i].gen != gen_count && !slots[i].blocked &&
                            (slots[i].last_event == 0 ||
                             too_old(it.now, slots[i].last_event, win))) begin
                            slots[i].syns = '0;
                            slots[i].acks = '0;
                            slots[i].flagged = 1'b0;
                        end
                    end
                end
                OP_TICK: begin
                    used = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slots[i].valid && slots[i].flagged && !slots[i].blocked && auto_blk) begin
                            slots[i].blocked = 1'b1;
                            slots[i].block_start = it.now;
                            push(KIND_BLOCKED, slots[i].addr);
                        end
                        if (slots[i].valid) used++;
                    end
                    if (used > EVICT_LIMIT)
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            if (slots[i].valid && !slots[i].flagged && !slots[i].blocked &&
                                !slots[i].sum_present &&
                                too_old(it.now, slots[i].last_event, idle_ttl))
                                slots[i].valid = 1'b0;
                end
                OP_EXPIRE: begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slots[i].valid && slots[i].blocked && it.now >= slots[i].block_start &&
                            it.now - slots[i].block_start >= blk_ttl) begin
                            slots[i].blocked = 1'b0;
                            slots[i].flagged = 1'b0;
                            slots[i].syns = '0;
                            slots[i].acks = '0;
                            push(KIND_EXPIRED, slots[i].addr);
                        end
                end
                default: ;
            endcase
            if (pending.size() == n) push(KIND_DONE, '0);
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] addr, logic last);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result kind %0d addr %h last %0d", $time, kind, addr, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind) begin
                $display("%0t kind: expected %0d actual %0d", $time, e.kind, kind);
                errors++;
            end
            if (addr !== e.addr) begin
                $display("%0t address: expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t last: expected %0d actual %0d", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [31:0] i_src_ip;
    logic [7:0]  i_ttl;
    logic [63:0] i_event_time;
    logic [7:0]  i_protocol;
    logic [31:0] i_flow_syns;
    logic [31:0] i_flow_acks;
    logic [63:0] i_first_seen;
    logic [63:0] i_last_seen;
    logic [63:0] i_time_now;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_result_kind;
    logic [31:0] o_address;
    logic        o_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    tracker_scoreboard sb;
    logic [63:0] clock_ns;
    int          fresh_addr;
    int          results_seen;

    syn_flood_source_tracker dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic send_item(t_item it);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation = it.op;
        i_src_ip = it.src;
        i_ttl = it.ttl;
        i_event_time = it.ev_time;
        i_protocol = it.proto;
        i_flow_syns = it.fsyn;
        i_flow_acks = it.fack;
        i_first_seen = it.first;
        i_last_seen = it.lastseen;
        i_time_now = it.now;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_valid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
    endtask

    function automatic t_item blank_item(logic [2:0] op);
        t_item it;
        it.op = op;
        it.src = {$urandom};
        it.ttl = $urandom_range(0, 255);
        it.ev_time = {$urandom, $urandom};
        it.proto = $urandom_range(0, 255);
        it.fsyn = $urandom;
        it.fack = $urandom;
        it.first = {$urandom, $urandom};
        it.lastseen = {$urandom, $urandom};
        it.now = clock_ns;
        return it;
    endfunction

    function automatic t_item flow_item(logic [31:0] src, logic [63:0] age);
        t_item it;
        it = blank_item(OP_FLOW);
        it.src = src;
        it.proto = TCP_PROTOCOL;
        it.fsyn = $urandom_range(0, 300);
        it.fack = $urandom_range(0, 60);
        it.lastseen = clock_ns - age;
        it.first = ($urandom_range(0, 3) == 0) ? 64'd0 : it.lastseen - $urandom_range(0, 4000000);
        return it;
    endfunction

    function automatic logic [31:0] pool_addr();
        return 32'h0A00_0000 + $urandom_range(0, fresh_addr);
    endfunction

    task automatic random_items(int count);
        t_item it;
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            clock_ns += $urandom_range(0, 2000000000);
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                repeat (6) begin
                    it = blank_item(OP_EVENT);
                    fresh_addr++;
                    it.src = 32'h0A00_0000 + fresh_addr;
                    it.ev_time = clock_ns - $urandom_range(0, 1000000000);
                    send_item(it);
                    done++;
                end
            end else if (pick < 6) begin
                it = blank_item(OP_EVENT);
                it.src = pool_addr();
                it.ev_time = clock_ns - $urandom_range(0, 3000000000);
                send_item(it);
                done++;
            end else if (pick < 12) begin
                send_item(flow_item(pool_addr(), {32'd0, $urandom} * 3));
                done++;
            end else if (pick < 14) begin
                send_item(blank_item(OP_SNAPSHOT));
                done++;
            end else if (pick < 16) begin
                send_item(blank_item(OP_TICK));
                done++;
            end else if (pick < 18) begin
                send_item(blank_item(OP_EXPIRE));
                done++;
            end else begin
                send_item(blank_item(3'($urandom_range(0, 7))));
                done++;
            end
        end
    endtask

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int hold;
        results_seen = 0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (results_seen == 40) hold = 600;
            else hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (hold > 0) begin
                i_ready = 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_result_kind, o_address, o_last);
            results_seen++;
        end
    end

    initial begin
        t_item it;
        int wait_cycles;
        sb = new();
        clock_ns = 64'd100000000000;
        fresh_addr = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_EVENT;
        i_src_ip = '0;
        i_ttl = '0;
        i_event_time = '0;
        i_protocol = '0;
        i_flow_syns = '0;
        i_flow_acks = '0;
        i_first_seen = '0;
        i_last_seen = '0;
        i_time_now = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FLAG_LEVEL;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: defaults
        it = blank_item(OP_EVENT);
        it.src = 32'h0A00_0000;
        it.ttl = 8'd0;
        it.ev_time = '1;
        send_item(it);
        it.ttl = 8'hFF;
        it.ev_time = '0;
        send_item(it);
        it = blank_item(OP_EVENT);
        it.src = 32'hFFFF_FFFF;
        send_item(it);
        it = flow_item(32'h0A00_0001, 64'd1000);
        it.fsyn = 32'hFFFF_FFFF;
        it.fack = 32'd0;
        send_item(it);
        it.fsyn = 32'd5;
        send_item(it);
        it = flow_item(32'h0A00_0002, 64'd0);
        it.fsyn = 32'd500;
        it.fack = 32'd0;
        send_item(it);
        it = flow_item(32'h0A00_0003, 64'd0);
        it.proto = 8'd17;
        send_item(it);
        it = flow_item(32'h0A00_0004, 64'd0);
        it.lastseen = '0;
        send_item(it);
        send_item(flow_item(32'h0A00_0005, 64'd20000000000));
        it = flow_item(32'h0A00_0006, 64'd0);
        it.first = clock_ns - 64'd20000000000;
        send_item(it);
        send_item(blank_item(OP_SNAPSHOT));
        send_item(blank_item(OP_TICK));
        send_item(blank_item(OP_TICK));
        send_item(blank_item(OP_EXPIRE));
        clock_ns += 64'd300000000000;
        send_item(blank_item(OP_EXPIRE));
        send_item(blank_item(3'd5));
        send_item(blank_item(3'd6));
        send_item(blank_item(3'd7));
        clock_ns += 64'd20000000000;
        send_item(blank_item(OP_SNAPSHOT));
        fresh_addr = 6;

        random_items(5);
        drain();
        write_reg(CFG_FLAG_LEVEL, 64'd0);
        write_reg(CFG_WINDOW, '1);
        write_reg(CFG_BLOCK_ENABLE, 64'd0);
        write_reg(CFG_BLOCK_TTL, 64'd0);
        write_reg(CFG_IDLE_TTL, 64'd0);
        random_items(5);
        drain();
        write_reg(CFG_FLAG_LEVEL, 64'hFFFF_FFFF);
        write_reg(CFG_WINDOW, 64'd0);
        write_reg(CFG_BLOCK_ENABLE, 64'd1);
        write_reg(CFG_BLOCK_TTL, '1);
        write_reg(CFG_IDLE_TTL, '1);
        random_items(5);
        drain();
        write_reg(CFG_FLAG_LEVEL, 64'd5);
        write_reg(CFG_WINDOW, 64'd5000000000);
        write_reg(CFG_BLOCK_TTL, 64'd2000000000);
        write_reg(CFG_IDLE_TTL, 64'd3000000000);

        // fill the table until new sources are dropped
        repeat (66) begin
            it = blank_item(OP_EVENT);
            fresh_addr++;
            it.src = 32'h0A00_0000 + fresh_addr;
            it.ev_time = clock_ns;
            send_item(it);
        end
        send_item(flow_item(32'h0B00_0000, 64'd0));
        clock_ns += 64'd10000000000;
        send_item(blank_item(OP_TICK));
        random_items(5);

        @(negedge i_clk);
        i_valid = 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
